// ===== src/ottr_pkg.sv =====
// ottr_pkg: shared constants, request/result types and scan-unit structs
// for the ordered timer table; used by every file of the block but ottr_ram
package ottr_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int NAME_BITS   = 8;
    localparam int TIME_BITS   = 32;
    localparam int PERIOD_BITS = 16;
    localparam int REQ_BITS    = 2;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [REQ_BITS-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_CANCEL = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_EXPIRE = 2'd2;

    typedef struct packed {
        logic [REQ_BITS-1:0]    req_type;
        logic [TIME_BITS-1:0]   deadline;
        logic [NAME_BITS-1:0]   name_id;
        logic [PERIOD_BITS-1:0] period;
        logic [TIME_BITS-1:0]   now;
    } t_req;

    typedef struct packed {
        logic                 fired;
        logic [NAME_BITS-1:0] fired_name;
        logic [TIME_BITS-1:0] fired_deadline;
        logic                 earliest_changed;
        logic                 found;
        logic                 overflow;
        logic                 table_empty;
        logic [TIME_BITS-1:0] next_deadline;
        logic                 last;
    } t_rsp;

    // one stored timer
    typedef struct packed {
        logic [TIME_BITS-1:0]   deadline;
        logic [NAME_BITS-1:0]   name;
        logic [PERIOD_BITS-1:0] period;
    } t_entry;

    localparam int ENTRY_W = TIME_BITS + NAME_BITS + PERIOD_BITS;
    localparam int FIRED_W = NAME_BITS + TIME_BITS;

    // per-beat control into the scan unit
    typedef struct packed {
        logic             start;
        logic             en;
        logic             excl;
        logic             ent_valid;
        logic             ent_due;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

    // accumulated scan results
    typedef struct packed {
        logic                 match;
        logic [IDX_W-1:0]     match_idx;
        logic                 free;
        logic [IDX_W-1:0]     free_idx;
        logic                 min_any;
        logic [TIME_BITS-1:0] min_dl;
        t_entry               sel;
        logic [IDX_W-1:0]     sel_idx;
        logic                 due_hit;
    } t_scan_res;

endpackage

// ===== src/ottr_intf.sv =====
// ottr_intf: valid/ready channel interfaces for requests and results
// depends on ottr_pkg for field widths
interface ottr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [ottr_pkg::REQ_BITS-1:0]        req_type;
    logic [ottr_pkg::TIME_BITS-1:0]       deadline;
    logic [ottr_pkg::NAME_BITS-1:0]       name_id;
    logic [ottr_pkg::PERIOD_BITS-1:0]     period;
    logic [ottr_pkg::TIME_BITS-1:0]       now;

    modport source (output valid, req_type, deadline, name_id, period, now, input ready);
    modport sink   (input valid, req_type, deadline, name_id, period, now, output ready);
endinterface

interface ottr_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             fired;
    logic [ottr_pkg::NAME_BITS-1:0]   fired_name;
    logic [ottr_pkg::TIME_BITS-1:0]   fired_deadline;
    logic                             earliest_changed;
    logic                             found;
    logic                             overflow;
    logic                             table_empty;
    logic [ottr_pkg::TIME_BITS-1:0]   next_deadline;
    logic                             last;

    modport source (output valid, fired, fired_name, fired_deadline, earliest_changed,
                    found, overflow, table_empty, next_deadline, last, input ready);
    modport sink   (input valid, fired, fired_name, fired_deadline, earliest_changed,
                    found, overflow, table_empty, next_deadline, last, output ready);
endinterface

// ===== src/ordered_timer_table_with_rearm.sv =====
// ordered_timer_table_with_rearm: top level, request sequencer, valid bits
// depends on ottr_pkg, ottr_intf, ottr_ram and ottr_scan
//
// Table of up to TABLE_DEPTH timers, each a (deadline, name) pair with a rearm
// period, held in a single-port-read memory that one compare unit walks one
// entry per cycle. An add or a cancel is one table pass plus a decision step,
// then one result. An expire takes one pass to collect the due entries, one
// pass per fired timer to pick the next one in (deadline, name) order, one
// more pass per periodic timer to check the rearm pair and find a slot and
// one final pass for the new earliest deadline, then reads each fired timer
// back from the report list and emits it as one result. The request channel
// is not ready from acceptance until the last result of that request has been
// taken. The table needs no clearing pass: only the valid bits are reset.
module ordered_timer_table_with_rearm (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ottr_req_if.sink  i_req,
    ottr_rsp_if.source o_rsp
);

    localparam int IDX_W = ottr_pkg::IDX_W;
    localparam int CNT_W = ottr_pkg::CNT_W;
    localparam int TW    = ottr_pkg::TIME_BITS;
    localparam int PW    = ottr_pkg::PERIOD_BITS;
    localparam int NW    = ottr_pkg::NAME_BITS;
    localparam int DEPTH = ottr_pkg::TABLE_DEPTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD_SCAN = 4'd1;
    localparam logic [3:0] S_ADD_DONE = 4'd2;
    localparam logic [3:0] S_CAN_SCAN = 4'd3;
    localparam logic [3:0] S_CAN_DONE = 4'd4;
    localparam logic [3:0] S_DUE_SCAN = 4'd5;
    localparam logic [3:0] S_DUE_DONE = 4'd6;
    localparam logic [3:0] S_SEL_SCAN = 4'd7;
    localparam logic [3:0] S_SEL_DONE = 4'd8;
    localparam logic [3:0] S_RA_SCAN  = 4'd9;
    localparam logic [3:0] S_RA_DONE  = 4'd10;
    localparam logic [3:0] S_FIN_SCAN = 4'd11;
    localparam logic [3:0] S_FIN_DONE = 4'd12;
    localparam logic [3:0] S_EMIT_RD  = 4'd13;
    localparam logic [3:0] S_EMIT_LD  = 4'd14;
    localparam logic [3:0] S_OUT_WAIT = 4'd15;

    logic [3:0]            r_state, n_state;
    ottr_pkg::t_req        r_req, n_req;
    logic [DEPTH-1:0]      r_valid, n_valid;   // entry holds a live timer
    logic [DEPTH-1:0]      r_due, n_due;       // entry fired, not yet reported
    logic [CNT_W-1:0]      r_cnt, n_cnt;       // fired timers this expire
    logic [CNT_W-1:0]      r_k, n_k;           // fired timers handled so far
    logic [TW-1:0]         r_key_dl, n_key_dl;
    logic [NW-1:0]         r_key_name, n_key_name;
    logic [PW-1:0]         r_ra_per, n_ra_per;
    ottr_pkg::t_rsp        r_o, n_o;
    logic                  r_o_valid, n_o_valid;

    // scan address generator
    logic                  r_issue;
    logic [IDX_W-1:0]      r_rd_addr;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;

    logic                  w_start;
    logic                  w_last;
    logic                  w_in_acc;
    ottr_pkg::t_req        w_in;
    ottr_pkg::t_scan_ctl   w_ctl;
    ottr_pkg::t_scan_res   w_res;
    ottr_pkg::t_entry      w_ent;
    logic [ottr_pkg::ENTRY_W-1:0] w_tab_rdata;
    logic                  w_tab_we;
    logic [IDX_W-1:0]      w_tab_waddr;
    ottr_pkg::t_entry      w_tab_wdata;
    logic                  w_buf_we;
    logic [ottr_pkg::FIRED_W-1:0] w_buf_rdata;
    logic [TW:0]           w_sum;
    logic [TW-1:0]         w_rearm_dl;
    logic                  w_ins;
    logic                  w_before;

    assign w_in.req_type = i_req.req_type;
    assign w_in.deadline = i_req.deadline;
    assign w_in.name_id  = i_req.name_id;
    assign w_in.period   = i_req.period;
    assign w_in.now      = i_req.now;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && (r_state == S_IDLE);

    assign w_last = r_rd_vld && (r_rd_idx == LAST_IDX);

    // timer table memory
    ottr_ram #(
        .WIDTH (ottr_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_tab_waddr),
        .i_wdata (w_tab_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_tab_rdata)
    );

    assign w_ent = ottr_pkg::t_entry'(w_tab_rdata);

    // fired timers in report order, {name, deadline}
    ottr_ram #(
        .WIDTH (ottr_pkg::FIRED_W),
        .DEPTH (DEPTH)
    ) u_fired (
        .i_clk   (i_clk),
        .i_we    (w_buf_we),
        .i_waddr (r_k[IDX_W-1:0]),
        .i_wdata ({w_res.sel.name, w_res.sel.deadline}),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (w_buf_rdata)
    );

    always_comb begin
        w_ctl.start     = w_start;
        w_ctl.en        = r_rd_vld;
        w_ctl.excl      = (r_state == S_CAN_SCAN);
        w_ctl.ent_valid = r_valid[r_rd_idx];
        w_ctl.ent_due   = r_due[r_rd_idx];
        w_ctl.idx       = r_rd_idx;
    end

    ottr_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_ent      (w_ent),
        .i_key_dl   (r_key_dl),
        .i_key_name (r_key_name),
        .i_now      (r_req.now),
        .o_res      (w_res)
    );

    // rearm deadline, saturating at the largest time value
    assign w_sum      = {1'b0, w_res.sel.deadline} + {{(TW + 1 - PW){1'b0}}, w_res.sel.period};
    assign w_rearm_dl = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];

    // add decision: inserted when no duplicate and a slot is free
    assign w_ins    = !w_res.match && w_res.free;
    assign w_before = w_ins && (!w_res.min_any || (r_key_dl < w_res.min_dl));

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_valid    = r_valid;
        n_due      = r_due;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_key_dl   = r_key_dl;
        n_key_name = r_key_name;
        n_ra_per   = r_ra_per;
        n_o        = r_o;
        n_o_valid  = r_o_valid;
        w_start    = 1'b0;
        w_tab_we   = 1'b0;
        w_tab_waddr = w_res.free_idx;
        w_tab_wdata = '{deadline: r_key_dl, name: r_key_name, period: r_ra_per};
        w_buf_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_req      = w_in;
                    n_key_dl   = w_in.deadline;
                    n_key_name = w_in.name_id;
                    n_ra_per   = w_in.period;
                    n_cnt      = '0;
                    n_k        = '0;
                    w_start    = 1'b1;
                    unique case (w_in.req_type)
                        ottr_pkg::REQ_ADD:    n_state = S_ADD_SCAN;
                        ottr_pkg::REQ_CANCEL: n_state = S_CAN_SCAN;
                        ottr_pkg::REQ_EXPIRE: n_state = S_DUE_SCAN;
                        default:              n_state = S_FIN_SCAN;
                    endcase
                end
            end
            S_ADD_SCAN: begin
                if (w_last) n_state = S_ADD_DONE;
            end
            S_ADD_DONE: begin
                if (w_ins) begin
                    n_valid[w_res.free_idx] = 1'b1;
                    w_tab_we = 1'b1;
                end
                n_o                  = '0;
                n_o.earliest_changed = w_before;
                n_o.overflow         = !w_res.match && !w_res.free;
                n_o.table_empty      = !(w_res.min_any || w_ins);
                n_o.next_deadline    = w_before ? r_key_dl :
                                       (w_res.min_any ? w_res.min_dl : '0);
                n_o.last             = 1'b1;
                n_o_valid            = 1'b1;
                n_state              = S_OUT_WAIT;
            end
            S_CAN_SCAN: begin
                if (w_last) n_state = S_CAN_DONE;
            end
            S_CAN_DONE: begin
                if (w_res.match) n_valid[w_res.match_idx] = 1'b0;
                n_o               = '0;
                n_o.found         = w_res.match;
                n_o.table_empty   = !w_res.min_any;
                n_o.next_deadline = w_res.min_any ? w_res.min_dl : '0;
                n_o.last          = 1'b1;
                n_o_valid         = 1'b1;
                n_state           = S_OUT_WAIT;
            end
            S_DUE_SCAN: begin
                // pull every due timer out of the live set
                if (r_rd_vld && w_res.due_hit) begin
                    n_due[r_rd_idx]   = 1'b1;
                    n_valid[r_rd_idx] = 1'b0;
                    n_cnt             = r_cnt + CNT_W'(1);
                end
                if (w_last) n_state = S_DUE_DONE;
            end
            S_DUE_DONE: begin
                w_start = 1'b1;
                n_state = (r_cnt == '0) ? S_FIN_SCAN : S_SEL_SCAN;
            end
            S_SEL_SCAN: begin
                if (w_last) n_state = S_SEL_DONE;
            end
            S_SEL_DONE: begin
                // smallest due timer goes to the report list
                n_due[w_res.sel_idx] = 1'b0;
                w_buf_we             = 1'b1;
                n_k                  = r_k + CNT_W'(1);
                w_start              = 1'b1;
                if (w_res.sel.period != '0) begin
                    n_key_dl   = w_rearm_dl;
                    n_key_name = w_res.sel.name;
                    n_ra_per   = w_res.sel.period;
                    n_state    = S_RA_SCAN;
                end else if ((r_k + CNT_W'(1)) == r_cnt) begin
                    n_state = S_FIN_SCAN;
                end else begin
                    n_state = S_SEL_SCAN;
                end
            end
            S_RA_SCAN: begin
                if (w_last) n_state = S_RA_DONE;
            end
            S_RA_DONE: begin
                // rearm onto an existing pair merges into it
                if (w_ins) begin
                    n_valid[w_res.free_idx] = 1'b1;
                    w_tab_we = 1'b1;
                end
                w_start = 1'b1;
                n_state = (r_k == r_cnt) ? S_FIN_SCAN : S_SEL_SCAN;
            end
            S_FIN_SCAN: begin
                if (w_last) n_state = S_FIN_DONE;
            end
            S_FIN_DONE: begin
                n_o               = '0;
                n_o.table_empty   = !w_res.min_any;
                n_o.next_deadline = w_res.min_any ? w_res.min_dl : '0;
                n_k               = '0;
                if (r_cnt == '0) begin
                    // nothing due, or unknown request type
                    n_o.last  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_OUT_WAIT;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_o.fired          = 1'b1;
                n_o.fired_name     = w_buf_rdata[ottr_pkg::FIRED_W-1:TW];
                n_o.fired_deadline = w_buf_rdata[TW-1:0];
                n_o.last           = (r_k == (r_cnt - CNT_W'(1)));
                n_o_valid          = 1'b1;
                n_state            = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (o_rsp.ready) begin
                    n_o_valid = 1'b0;
                    if (r_o.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_due     <= '0;
            r_cnt     <= '0;
            r_k       <= '0;
            r_o_valid <= 1'b0;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_due     <= n_due;
            r_cnt     <= n_cnt;
            r_k       <= n_k;
            r_o_valid <= n_o_valid;
            r_rd_vld  <= r_issue;
            if (w_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_rd_addr == LAST_IDX)) begin
                r_issue <= 1'b0;
            end
        end
    end

    // payload and scan addresses
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_key_dl   <= n_key_dl;
        r_key_name <= n_key_name;
        r_ra_per   <= n_ra_per;
        r_o        <= n_o;
        r_rd_idx   <= r_rd_addr;
        if (w_start) begin
            r_rd_addr <= '0;
        end else if (r_issue && (r_rd_addr != LAST_IDX)) begin
            r_rd_addr <= r_rd_addr + IDX_W'(1);
        end
    end

    assign o_rsp.valid            = r_o_valid;
    assign o_rsp.fired            = r_o.fired;
    assign o_rsp.fired_name       = r_o.fired_name;
    assign o_rsp.fired_deadline   = r_o.fired_deadline;
    assign o_rsp.earliest_changed = r_o.earliest_changed;
    assign o_rsp.found            = r_o.found;
    assign o_rsp.overflow         = r_o.overflow;
    assign o_rsp.table_empty      = r_o.table_empty;
    assign o_rsp.next_deadline    = r_o.next_deadline;
    assign o_rsp.last             = r_o.last;

endmodule

// ===== src/ottr_ram.sv =====
// ottr_ram: generic single-write, single-read RAM with registered read
// no dependencies
module ottr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ottr_scan.sv =====
// ottr_scan: shared compare unit walked over the table one entry a beat
// finds pair match, first free slot, earliest deadline and smallest due timer
// depends on ottr_pkg
module ottr_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ottr_pkg::t_scan_ctl            i_ctl,
    input  ottr_pkg::t_entry               i_ent,
    input  logic [ottr_pkg::TIME_BITS-1:0] i_key_dl,
    input  logic [ottr_pkg::NAME_BITS-1:0] i_key_name,
    input  logic [ottr_pkg::TIME_BITS-1:0] i_now,
    output ottr_pkg::t_scan_res            o_res
);

    logic                           r_match;
    logic [ottr_pkg::IDX_W-1:0]     r_match_idx;
    logic                           r_free;
    logic [ottr_pkg::IDX_W-1:0]     r_free_idx;
    logic                           r_min_any;
    logic [ottr_pkg::TIME_BITS-1:0] r_min_dl;
    logic                           r_sel_any;
    ottr_pkg::t_entry               r_sel;
    logic [ottr_pkg::IDX_W-1:0]     r_sel_idx;

    logic w_hit;
    logic w_take_match;
    logic w_take_free;
    logic w_take_min;
    logic w_take_sel;
    logic w_less;

    assign w_hit = i_ctl.ent_valid && (i_ent.deadline == i_key_dl) && (i_ent.name == i_key_name);
    assign w_less = (i_ent.deadline < r_sel.deadline) ||
                    ((i_ent.deadline == r_sel.deadline) && (i_ent.name < r_sel.name));

    assign w_take_match = i_ctl.en && w_hit && !r_match;
    assign w_take_free  = i_ctl.en && !i_ctl.ent_valid && !i_ctl.ent_due && !r_free;
    assign w_take_min   = i_ctl.en && i_ctl.ent_valid && !(i_ctl.excl && w_hit) &&
                          (!r_min_any || (i_ent.deadline < r_min_dl));
    assign w_take_sel   = i_ctl.en && i_ctl.ent_due && (!r_sel_any || w_less);

    // flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_match   <= 1'b0;
            r_free    <= 1'b0;
            r_min_any <= 1'b0;
            r_sel_any <= 1'b0;
        end else begin
            if (w_take_match) r_match   <= 1'b1;
            if (w_take_free)  r_free    <= 1'b1;
            if (w_take_min)   r_min_any <= 1'b1;
            if (w_take_sel)   r_sel_any <= 1'b1;
        end
    end

    // captured values
    always_ff @(posedge i_clk) begin
        if (w_take_match) r_match_idx <= i_ctl.idx;
        if (w_take_free)  r_free_idx  <= i_ctl.idx;
        if (w_take_min)   r_min_dl    <= i_ent.deadline;
        if (w_take_sel) begin
            r_sel     <= i_ent;
            r_sel_idx <= i_ctl.idx;
        end
    end

    always_comb begin
        o_res.match     = r_match;
        o_res.match_idx = r_match_idx;
        o_res.free      = r_free;
        o_res.free_idx  = r_free_idx;
        o_res.min_any   = r_min_any;
        o_res.min_dl    = r_min_dl;
        o_res.sel       = r_sel;
        o_res.sel_idx   = r_sel_idx;
        o_res.due_hit   = i_ctl.ent_valid && (i_ent.deadline < i_now);
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for ordered_timer_table_with_rearm, with a directed
// table followed by random add/cancel/expire traffic and an in-bench timer table
// depends on ottr_pkg, ottr_intf and the block's rtl
module tb;
    import ottr_pkg::*;

    // request code the block does not know
    localparam logic [REQ_BITS-1:0] REQ_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 410;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ottr_req_if req_if();
    ottr_rsp_if rsp_if();

    ordered_timer_table_with_rearm dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #6 i_clk = ~i_clk;

    // timer table as the bench sees it, updated on each accepted request
    logic                   tbl_valid    [TABLE_DEPTH];
    logic [TIME_BITS-1:0]   tbl_deadline [TABLE_DEPTH];
    logic [NAME_BITS-1:0]   tbl_name     [TABLE_DEPTH];
    logic [PERIOD_BITS-1:0] tbl_period   [TABLE_DEPTH];

    t_rsp      expected_rsp [$];
    t_stim_row directed_tab [$];
    int        errors = 0;
    int        cycle_count = 0;
    int        items_sent = 0;
    bit        steady_flow = 1'b0;
    logic [TIME_BITS-1:0] cur_tick;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int find_timer(logic [TIME_BITS-1:0] dl, logic [NAME_BITS-1:0] nm);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i] && tbl_deadline[i] == dl && tbl_name[i] == nm)
                return i;
        return -1;
    endfunction

    // earliest live deadline, 0 when the table is empty
    function automatic bit earliest_deadline(output logic [TIME_BITS-1:0] dl);
        bit any;
        any = 1'b0;
        dl = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_valid[i] && (!any || tbl_deadline[i] < dl)) begin
                dl = tbl_deadline[i];
                any = 1'b1;
            end
        end
        return any;
    endfunction

    // 1 inserted, 0 pair already present, -1 table full
    function automatic int insert_timer(logic [TIME_BITS-1:0] dl, logic [NAME_BITS-1:0] nm,
                                        logic [PERIOD_BITS-1:0] per);
        if (find_timer(dl, nm) >= 0)
            return 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i]    = 1'b1;
                tbl_deadline[i] = dl;
                tbl_name[i]     = nm;
                tbl_period[i]   = per;
                return 1;
            end
        end
        return -1;
    endfunction

    // adds one result at the tail of the expected list
    function automatic void queue_expected(t_rsp x);
        expected_rsp.insert(expected_rsp.size(), x);
    endfunction

    // applies one request to the table and queues the results it should give;
    // a typed row replaces the computed result with the one written in the table
    function automatic void apply_timer_request(t_req r, bit typed, t_rsp typed_rsp);
        t_rsp                 outs [TABLE_DEPTH];
        t_rsp                 blank;
        t_entry               due [TABLE_DEPTH];
        t_entry               swap;
        bit                   rearm_ovf [TABLE_DEPTH];
        logic [TIME_BITS-1:0] cur;
        logic [TIME_BITS:0]   sum;
        int                   nout;
        int                   cnt;
        int                   slot;
        bit                   any;

        blank = '0;
        blank.last = 1'b1;
        nout = 0;
        cnt = 0;
        case (r.req_type)
            REQ_ADD: begin
                any = earliest_deadline(cur);
                slot = insert_timer(r.deadline, r.name_id, r.period);
                blank.earliest_changed = (slot == 1) && (!any || r.deadline < cur);
                blank.overflow = (slot < 0);
                outs[0] = blank;
                nout = 1;
            end
            REQ_CANCEL: begin
                slot = find_timer(r.deadline, r.name_id);
                if (slot >= 0)
                    tbl_valid[slot] = 1'b0;
                blank.found = (slot >= 0);
                outs[0] = blank;
                nout = 1;
            end
            REQ_EXPIRE: begin
                // pull every timer strictly below now
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_valid[i] && tbl_deadline[i] < r.now) begin
                        due[cnt].deadline = tbl_deadline[i];
                        due[cnt].name     = tbl_name[i];
                        due[cnt].period   = tbl_period[i];
                        tbl_valid[i] = 1'b0;
                        cnt++;
                    end
                end
                // order by deadline, then name
                for (int i = 0; i < cnt; i++) begin
                    for (int j = i + 1; j < cnt; j++) begin
                        if (due[j].deadline < due[i].deadline ||
                            (due[j].deadline == due[i].deadline && due[j].name < due[i].name)) begin
                            swap = due[i];
                            due[i] = due[j];
                            due[j] = swap;
                        end
                    end
                end
                // periodic timers come back at deadline + period, saturating
                for (int i = 0; i < cnt; i++) begin
                    rearm_ovf[i] = 1'b0;
                    if (due[i].period != 0) begin
                        sum = {1'b0, due[i].deadline} + due[i].period;
                        if (insert_timer(sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0],
                                         due[i].name, due[i].period) < 0)
                            rearm_ovf[i] = 1'b1;
                    end
                end
                if (cnt == 0) begin
                    outs[0] = blank;
                    nout = 1;
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        outs[i] = '0;
                        outs[i].fired          = 1'b1;
                        outs[i].fired_name     = due[i].name;
                        outs[i].fired_deadline = due[i].deadline;
                        outs[i].overflow       = rearm_ovf[i];
                        outs[i].last           = (i == cnt - 1);
                    end
                    nout = cnt;
                end
            end
            default: begin
                outs[0] = blank;
                nout = 1;
            end
        endcase

        // table status is taken after the whole request
        any = earliest_deadline(cur);
        if (typed) begin
            queue_expected(typed_rsp);
        end else begin
            for (int i = 0; i < nout; i++) begin
                outs[i].table_empty   = !any;
                outs[i].next_deadline = cur;
                queue_expected(outs[i]);
            end
        end
    endfunction

    function automatic t_req mk_req(logic [REQ_BITS-1:0] ty, logic [TIME_BITS-1:0] dl,
                                    logic [NAME_BITS-1:0] nm, logic [PERIOD_BITS-1:0] per,
                                    logic [TIME_BITS-1:0] nw);
        t_req r;
        r.req_type = ty;
        r.deadline = dl;
        r.name_id  = nm;
        r.period   = per;
        r.now      = nw;
        return r;
    endfunction

    // single non-fired result with the given flags and table status
    function automatic t_rsp status_rsp(bit ec, bit fnd, bit ovf, bit empty,
                                        logic [TIME_BITS-1:0] nd);
        t_rsp s;
        s = '0;
        s.earliest_changed = ec;
        s.found            = fnd;
        s.overflow         = ovf;
        s.table_empty      = empty;
        s.next_deadline    = nd;
        s.last             = 1'b1;
        return s;
    endfunction

    function automatic void add_row(t_req r, bit typed, t_rsp e);
        t_stim_row row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = e;
        directed_tab.insert(directed_tab.size(), row);
    endfunction

    function automatic logic [PERIOD_BITS-1:0] rand_period();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4, 5, 6, 7: return PERIOD_BITS'($urandom_range(1, 200));
            8:          return PERIOD_BITS'($urandom_range(0, 65535));
            default:    return '1;
        endcase
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_deadline();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            3:       return '1 - $urandom_range(0, 500);
            default: return cur_tick + $urandom_range(0, 400);
        endcase
    endfunction

    // random request, mostly around the running time so expires find work
    function automatic t_req rand_request();
        t_req r;
        int   pick;
        int   live [$];
        r = mk_req(REQ_ADD, rand_deadline(),
                   ($urandom_range(0, 3) == 0) ? NAME_BITS'($urandom_range(0, 255))
                                               : NAME_BITS'($urandom_range(0, 7)),
                   rand_period(), $urandom());
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            r.req_type = REQ_ADD;
        end else if (pick < 70) begin
            r.req_type = REQ_CANCEL;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (tbl_valid[i])
                    live.insert(live.size(), i);
            // most cancels aim at a live timer
            if (live.size() > 0 && $urandom_range(0, 9) < 6) begin
                pick = live[$urandom_range(0, live.size() - 1)];
                r.deadline = tbl_deadline[pick];
                r.name_id  = tbl_name[pick];
            end
        end else if (pick < 97) begin
            r.req_type = REQ_EXPIRE;
            case ($urandom_range(0, 9))
                0:       r.now = '0;
                1:       r.now = '1;
                2:       r.now = $urandom();
                default: begin
                    r.now = cur_tick + $urandom_range(0, 300);
                    cur_tick = r.now;
                end
            endcase
        end else begin
            r.req_type = REQ_NONE;
        end
        return r;
    endfunction

    // one request: random hold-off unless in steady flow, then hold valid until the block takes it
    task automatic send_request(t_req r, bit typed, t_rsp typed_rsp);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.req_type = r.req_type;
        req_if.deadline = r.deadline;
        req_if.name_id  = r.name_id;
        req_if.period   = r.period;
        req_if.now      = r.now;
        do @(posedge i_clk); while (!req_if.ready);
        apply_timer_request(r, typed, typed_rsp);
        if (r.req_type != REQ_NONE)
            items_sent++;
    endtask

    task automatic check_field(string fname, logic [TIME_BITS-1:0] want,
                               logic [TIME_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: result field %s expected %0h actual %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    // result side: random stall before each result unless in steady flow, checked in arrival order
    initial begin
        int   stall;
        t_rsp want;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 10);
            @(negedge i_clk);
            if (stall > 0) begin
                rsp_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none actual fired=%0b name=%0h dl=%0h",
                         $time, rsp_if.fired, rsp_if.fired_name, rsp_if.fired_deadline);
                errors++;
            end else begin
                want = expected_rsp.pop_front();
                check_field("fired",            want.fired,            rsp_if.fired);
                check_field("fired_name",       want.fired_name,       rsp_if.fired_name);
                check_field("fired_deadline",   want.fired_deadline,   rsp_if.fired_deadline);
                check_field("earliest_changed", want.earliest_changed, rsp_if.earliest_changed);
                check_field("found",            want.found,            rsp_if.found);
                check_field("overflow",         want.overflow,         rsp_if.overflow);
                check_field("table_empty",      want.table_empty,      rsp_if.table_empty);
                check_field("next_deadline",    want.next_deadline,    rsp_if.next_deadline);
                check_field("last",             want.last,             rsp_if.last);
            end
        end
    end

    initial begin
        t_rsp                 none;
        t_req                 r;
        logic [TIME_BITS-1:0] base;
        logic [TIME_BITS-1:0] drain_dl [$];
        logic [NAME_BITS-1:0] drain_nm [$];
        int                   live [$];
        int                   pick;
        bit                   first_burst;

        none = '0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_ADD;
        req_if.deadline = '0;
        req_if.name_id  = '0;
        req_if.period   = '0;
        req_if.now      = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tbl_valid[i] = 1'b0;
        cur_tick = $urandom_range(0, 1 << 20);

        // empty table: expire, cancel and an unknown code see nothing
        add_row(mk_req(REQ_EXPIRE, '0, '0, '0, '0), 1, status_rsp(0, 0, 0, 1, '0));
        add_row(mk_req(REQ_CANCEL, 5, 1, '0, '0), 1, status_rsp(0, 0, 0, 1, '0));
        add_row(mk_req(REQ_NONE, '1, '1, '1, '1), 1, status_rsp(0, 0, 0, 1, '0));
        // first add, then a duplicate pair that must not change anything
        add_row(mk_req(REQ_ADD, 100, 1, '0, '0), 1, status_rsp(1, 0, 0, 0, 100));
        add_row(mk_req(REQ_ADD, 100, 1, 7, '0), 1, status_rsp(0, 0, 0, 0, 100));
        // field extremes
        add_row(mk_req(REQ_ADD, '0, '0, '1, '0), 1, status_rsp(1, 0, 0, 0, '0));
        add_row(mk_req(REQ_ADD, '1, '1, '1, '0), 1, status_rsp(0, 0, 0, 0, '0));
        add_row(mk_req(REQ_ADD, 32'hFFFF_FFF0, 2, '1, '0), 0, none);
        add_row(mk_req(REQ_CANCEL, 100, 2, '0, '0), 0, none);
        // saturating rearm; the timer at the top value never fires
        add_row(mk_req(REQ_EXPIRE, '0, '0, '0, '1), 0, none);
        add_row(mk_req(REQ_EXPIRE, '0, '0, '0, '1), 0, none);
        add_row(mk_req(REQ_CANCEL, '1, '1, '0, '0), 0, none);
        add_row(mk_req(REQ_CANCEL, '1, 2, '0, '0), 0, none);
        // equal deadlines fire in name order
        add_row(mk_req(REQ_ADD, 50, 9, '0, '0), 0, none);
        add_row(mk_req(REQ_ADD, 50, 3, '0, '0), 0, none);
        add_row(mk_req(REQ_ADD, 40, 7, '0, '0), 0, none);
        // rearm lands on a pair that is already present
        add_row(mk_req(REQ_ADD, 10, 5, 10, '0), 0, none);
        add_row(mk_req(REQ_ADD, 20, 5, '0, '0), 0, none);
        add_row(mk_req(REQ_EXPIRE, '0, '0, '0, 15), 0, none);
        add_row(mk_req(REQ_EXPIRE, '0, '0, '0, 51), 0, none);
        add_row(mk_req(REQ_NONE, '0, '0, '0, '0), 0, none);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_tab[k])
            send_request(directed_tab[k].req, directed_tab[k].typed, directed_tab[k].rsp);

        items_sent = 0;
        first_burst = 1'b1;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 29) == 0)
                steady_flow = !steady_flow;
            if (first_burst || $urandom_range(0, 24) == 0) begin
                first_burst = 1'b0;
                // hold off until the block has delivered everything
                @(negedge i_clk);
                req_if.valid = 1'b0;
                while (expected_rsp.size() != 0)
                    @(posedge i_clk);
                // fill past capacity with distinct pairs
                base = cur_tick + 1000;
                for (int k = 0; k < TABLE_DEPTH + 2; k++)
                    send_request(mk_req(REQ_ADD, base + k, NAME_BITS'($urandom_range(0, 255)),
                                        rand_period(), '0), 0, none);
                // duplicate on a full table is not an overflow
                live.delete();
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (tbl_valid[i])
                        live.insert(live.size(), i);
                if (live.size() > 0) begin
                    pick = live[$urandom_range(0, live.size() - 1)];
                    send_request(mk_req(REQ_ADD, tbl_deadline[pick], tbl_name[pick],
                                        rand_period(), '0), 0, none);
                end
                send_request(mk_req(REQ_EXPIRE, '0, '0, '0,
                                    base + $urandom_range(0, TABLE_DEPTH + 4)), 0, none);
                // drain whatever is left, including saturated timers
                drain_dl.delete();
                drain_nm.delete();
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_valid[i]) begin
                        drain_dl.insert(drain_dl.size(), tbl_deadline[i]);
                        drain_nm.insert(drain_nm.size(), tbl_name[i]);
                    end
                end
                foreach (drain_dl[k])
                    send_request(mk_req(REQ_CANCEL, drain_dl[k], drain_nm[k], '0, '0), 0, none);
                cur_tick = base + TABLE_DEPTH + 4;
            end else begin
                r = rand_request();
                send_request(r, 0, none);
            end
        end

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge i_clk);
        // room for any stray result after the last expected one
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ottr_pkg.sv
src/ottr_intf.sv
src/ottr_ram.sv
src/ottr_scan.sv
src/ordered_timer_table_with_rearm.sv
tb/sv/tb.sv
